>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Immediate-consequence check: prop is a full property expression.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle check: cond at one edge implies conseq at the next.
`define ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, conseq, msg)

`endif

`endif

>>> rtl/core/gpe_pkg.sv
// Package for the GPIO port with edge interrupts: word types, command and
// register-select codes, pin count and pin mask. No dependencies.
package gpe_pkg;

  localparam int PIN_WIDTH = 12;  // fixed field width on the ports
  localparam int PIN_COUNT = 12;  // implemented pins, 1..12 (at most PIN_WIDTH)

  // Bits at or above PIN_COUNT are held at zero everywhere.
  localparam logic [PIN_WIDTH-1:0] PIN_MASK =
    (PIN_COUNT >= PIN_WIDTH) ? {PIN_WIDTH{1'b1}} :
    PIN_WIDTH'((64'd1 << PIN_COUNT) - 64'd1);

  localparam logic [1:0] CMD_READ       = 2'd0;
  localparam logic [1:0] CMD_WRITE      = 2'd1;
  localparam logic [1:0] CMD_MASK_WRITE = 2'd2;
  localparam logic [1:0] CMD_SAMPLE     = 2'd3;

  localparam logic [2:0] REG_DATA       = 3'd0;
  localparam logic [2:0] REG_DIRECTION  = 3'd1;
  localparam logic [2:0] REG_POLARITY   = 3'd2;
  localparam logic [2:0] REG_BOTH_EDGE  = 3'd3;
  localparam logic [2:0] REG_ENABLE     = 3'd4;
  localparam logic [2:0] REG_RAW_STATUS = 3'd5;
  localparam logic [2:0] REG_MASKED_STS = 3'd6;
  localparam logic [2:0] REG_CLEAR      = 3'd7;

  typedef struct packed {
    logic [1:0]           command;
    logic [2:0]           reg_select;
    logic [PIN_WIDTH-1:0] access_mask;
    logic [PIN_WIDTH-1:0] write_value;
    logic [PIN_WIDTH-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [PIN_WIDTH-1:0] read_value;
    logic [PIN_WIDTH-1:0] pad_out;
    logic [PIN_WIDTH-1:0] pad_enable;
    logic                 irq;
    logic                 bad_access;
  } out_item_t;

endpackage

>>> rtl/core/gpio_port_edge_interrupt_core.sv
// GPIO port with edge interrupts: register file, edge detect, result register.
// Depends on gpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

// One 12-pin GPIO port. Each input word is a register read, register write,
// masked data write or pin sample; each gives exactly one result word in the
// cycle after it is accepted, taken from a single output register. A new word
// is accepted every cycle while in_stall is low; in_stall rises only while the
// output register holds a word that the downstream side is stalling, so the
// rate is set by that register alone. Results show the state after the word
// has been applied: pad drive, pad enables and the interrupt line.
module gpio_port_edge_interrupt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gpe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gpe_pkg::out_item_t out_item
);
  import gpe_pkg::*;

  logic [PIN_WIDTH-1:0] out_latch, out_latch_next;
  logic [PIN_WIDTH-1:0] direction, direction_next;
  logic [PIN_WIDTH-1:0] rise_select, rise_select_next;
  logic [PIN_WIDTH-1:0] both_select, both_select_next;
  logic [PIN_WIDTH-1:0] irq_enable, irq_enable_next;
  logic [PIN_WIDTH-1:0] raw_status, raw_status_next;
  logic [PIN_WIDTH-1:0] last_pins, last_pins_next;

  logic [PIN_WIDTH-1:0] amask, wval, pins;
  logic [PIN_WIDTH-1:0] rising, falling, events;
  logic [PIN_WIDTH-1:0] rd;
  logic                 bad;
  logic                 accept;
  out_item_t            result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign amask = in_item.access_mask & PIN_MASK;
  assign wval  = in_item.write_value & PIN_MASK;
  assign pins  = in_item.pin_levels & PIN_MASK;

  assign rising  = pins & ~last_pins;
  assign falling = ~pins & last_pins;
  assign events  = ((both_select & (rising | falling)) |
                    (~both_select & ((rise_select & rising) | (~rise_select & falling))))
                   & PIN_MASK;

  always_comb begin
    out_latch_next   = out_latch;
    direction_next   = direction;
    rise_select_next = rise_select;
    both_select_next = both_select;
    irq_enable_next  = irq_enable;
    raw_status_next  = raw_status;
    last_pins_next   = last_pins;
    rd               = '0;
    bad              = 1'b0;
    case (in_item.command)
      CMD_READ: begin
        case (in_item.reg_select)
          REG_DATA:       rd = (out_latch & direction) | (last_pins & ~direction);
          REG_DIRECTION:  rd = direction;
          REG_POLARITY:   rd = rise_select;
          REG_BOTH_EDGE:  rd = both_select;
          REG_ENABLE:     rd = irq_enable;
          REG_RAW_STATUS: rd = raw_status;
          REG_MASKED_STS: rd = raw_status & irq_enable;
          default:        rd = '0;  // clear is write-only
        endcase
      end
      CMD_WRITE: begin
        case (in_item.reg_select)
          REG_DATA:       out_latch_next   = wval;
          REG_DIRECTION:  direction_next   = wval;
          REG_POLARITY:   rise_select_next = wval;
          REG_BOTH_EDGE:  both_select_next = wval;
          REG_ENABLE:     irq_enable_next  = wval;
          REG_RAW_STATUS: bad = 1'b1;
          REG_MASKED_STS: bad = 1'b1;
          default:        raw_status_next  = raw_status & ~wval;
        endcase
      end
      CMD_MASK_WRITE: begin
        out_latch_next = (out_latch & ~amask) | (wval & amask);
      end
      default: begin
        raw_status_next = raw_status | events;
        last_pins_next  = pins;
      end
    endcase

    result.read_value = rd & PIN_MASK;
    result.pad_out    = out_latch_next;
    result.pad_enable = direction_next;
    result.irq        = |(raw_status_next & irq_enable_next);
    result.bad_access = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch   <= '0;
      direction   <= '0;
      rise_select <= '0;
      both_select <= '0;
      irq_enable  <= '0;
      raw_status  <= '0;
      last_pins   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        out_latch   <= out_latch_next;
        direction   <= direction_next;
        rise_select <= rise_select_next;
        both_select <= both_select_next;
        irq_enable  <= irq_enable_next;
        raw_status  <= raw_status_next;
        last_pins   <= last_pins_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

  // State only moves with a new result word, so a held word stays consistent.
  `ASSERT_CLK(a_irq_matches, clk, rst, out_valid |-> (out_item.irq == |(raw_status & irq_enable)), "irq does not match enabled status")
  `ASSERT_CLK(a_pad_matches, clk, rst, out_valid |-> (out_item.pad_enable == direction && out_item.pad_out == out_latch), "pad word does not match registers")
  `ASSERT_NEXT(a_bad_status_write, clk, rst, accept && in_item.command == CMD_WRITE && (in_item.reg_select == REG_RAW_STATUS || in_item.reg_select == REG_MASKED_STS), out_valid && out_item.bad_access, "status write not flagged")
  `ASSERT_NEXT(a_nonread_zero, clk, rst, accept && in_item.command != CMD_READ, out_item.read_value == '0, "read_value not zero for non-read")

endmodule
